@@ rtl/backend_load_balancer_top_macros.svh @@
// Assertion macros shared by the load balancer checker.
`ifndef BACKEND_LOAD_BALANCER_TOP_MACROS_SVH
`define BACKEND_LOAD_BALANCER_TOP_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define BLB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check a next-cycle implication outside reset.
`define BLB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/blb_pkg.sv @@
// Shared constants, types and helpers of the backend load balancer.
package blb_pkg;
  localparam int NumSlots = 16;
  localparam int SlotW = 4;
  localparam int CntW = 5;

  typedef enum logic [3:0] {
    CmdAdd = 4'd0, CmdRemove = 4'd1, CmdRoute = 4'd2, CmdSuccess = 4'd3,
    CmdFailure = 4'd4, CmdHealthy = 4'd5, CmdUnhealthy = 4'd6, CmdTick = 4'd7,
    CmdSetResp = 4'd8
  } cmd_e;

  localparam logic [2:0] StratRr = 3'd0;
  localparam logic [2:0] StratLeastConn = 3'd1;
  localparam logic [2:0] StratHash = 3'd3;
  localparam logic [2:0] StratLeastResp = 3'd4;

  localparam logic [1:0] CfgStrategy = 2'd0;
  localparam logic [1:0] CfgFailLimit = 2'd1;
  localparam logic [1:0] CfgBrkThresh = 2'd2;

  typedef enum logic [2:0] {
    StIdle, StCount, StDiv, StScan, StApply, StDone
  } state_e;

  // Operation broadcast from the controller to every cell.
  typedef struct packed {
    logic             count_en;
    logic             scan_en;
    logic             apply_en;
    logic [3:0]       cmd;
    logic [SlotW-1:0] slot;
    logic             slot_valid;
    logic             init_h;
    logic [SlotW-1:0] chosen;
    logic             chosen_ok;
    logic [19:0]      rt;
    logic [7:0]       fail_limit;
    logic [7:0]       brk_thresh;
  } cell_op_t;

  // Running word handed from cell to cell during a scan.
  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] best;
    logic [19:0]      key;
    logic [CntW-1:0]  k;
    logic [CntW-1:0]  n;
  } chain_t;
endpackage

@@ rtl/blb_cell.sv @@
// One backend slot: its state and one link of the scan chain.
module blb_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [blb_pkg::SlotW-1:0] idx_i,
  input  blb_pkg::cell_op_t    op_i,
  input  logic [2:0]           strat_i,
  input  logic [blb_pkg::CntW-1:0] target_i,
  input  blb_pkg::chain_t      chain_i,
  output blb_pkg::chain_t      chain_o,
  output logic                 healthy_o,
  output logic                 open_o,
  output logic                 present_o
);
  logic present_q, present_d, healthy_q, healthy_d, open_q, open_d;
  logic [7:0] fail_q, fail_d, bcnt_q, bcnt_d;
  logic [15:0] conn_q, conn_d;
  logic [19:0] resp_q, resp_d;
  logic elig, mine, pick_here;
  logic [19:0] key;
  logic [7:0] fail_inc, bcnt_inc;
  blb_pkg::chain_t chain_d, chain_q;

  assign elig = present_q && healthy_q && !open_q;
  assign mine = op_i.slot_valid && (op_i.slot == idx_i);
  assign key  = (strat_i == blb_pkg::StratLeastConn) ? {4'd0, conn_q} : resp_q;

  // Fold this slot into the running count or selection.
  always_comb begin
    chain_d = chain_i;
    pick_here = 1'b0;
    if (op_i.count_en && elig) begin
      chain_d.n = chain_i.n + 1'b1;
    end
    if (op_i.scan_en && elig) begin
      if (strat_i == blb_pkg::StratLeastConn || strat_i == blb_pkg::StratLeastResp) begin
        pick_here = !chain_i.found || (key < chain_i.key);
      end else begin
        pick_here = !chain_i.found && (chain_i.k == target_i);
        chain_d.k = chain_i.k + 1'b1;
      end
      if (pick_here) begin
        chain_d.found = 1'b1;
        chain_d.best = idx_i;
        chain_d.key = key;
      end
    end
  end

  // Register the chain link toward the next cell.
  always_ff @(posedge clk_i) begin
    chain_q <= chain_d;
  end
  assign chain_o = chain_q;

  // Update this slot's state for the command.
  always_comb begin
    present_d = present_q;
    healthy_d = healthy_q;
    open_d = open_q;
    fail_d = fail_q;
    bcnt_d = bcnt_q;
    conn_d = conn_q;
    resp_d = resp_q;
    fail_inc = (fail_q == 8'hFF) ? fail_q : fail_q + 8'd1;
    bcnt_inc = (bcnt_q == 8'hFF) ? bcnt_q : bcnt_q + 8'd1;
    if (op_i.apply_en) begin
      case (op_i.cmd)
        blb_pkg::CmdAdd: begin
          if (mine && !present_q) begin
            present_d = 1'b1; healthy_d = op_i.init_h; open_d = 1'b0;
            fail_d = '0; bcnt_d = '0; conn_d = '0;
          end
        end
        blb_pkg::CmdRemove: begin
          if (mine && present_q) begin
            present_d = 1'b0; healthy_d = 1'b0; open_d = 1'b0;
            fail_d = '0; bcnt_d = '0; conn_d = '0;
          end
        end
        blb_pkg::CmdRoute: begin
          if (op_i.chosen_ok && op_i.chosen == idx_i && conn_q != 16'hFFFF) begin
            conn_d = conn_q + 16'd1;
          end
        end
        blb_pkg::CmdSuccess, blb_pkg::CmdFailure: begin
          if (mine && present_q) begin
            if (op_i.cmd == blb_pkg::CmdFailure) begin
              bcnt_d = bcnt_inc;
              if (bcnt_inc >= op_i.brk_thresh) open_d = 1'b1;
            end
            if (conn_q != 16'd0) conn_d = conn_q - 16'd1;
          end
        end
        blb_pkg::CmdHealthy: begin
          if (mine && present_q) begin
            healthy_d = 1'b1; fail_d = '0;
          end
        end
        blb_pkg::CmdUnhealthy: begin
          if (mine && present_q) healthy_d = 1'b0;
        end
        blb_pkg::CmdTick: begin
          if (present_q) begin
            if (fail_q < op_i.fail_limit) begin
              if (!healthy_q) begin
                healthy_d = 1'b1; fail_d = '0;
              end
            end else begin
              fail_d = fail_inc;
              healthy_d = 1'b0;
            end
          end
        end
        blb_pkg::CmdSetResp: begin
          if (mine) resp_d = op_i.rt;
        end
        default: ;
      endcase
    end
  end

  // Hold slot state; reset clears it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0; healthy_q <= 1'b0; open_q <= 1'b0;
      fail_q <= '0; bcnt_q <= '0; conn_q <= '0; resp_q <= '0;
    end else begin
      present_q <= present_d; healthy_q <= healthy_d; open_q <= open_d;
      fail_q <= fail_d; bcnt_q <= bcnt_d; conn_q <= conn_d; resp_q <= resp_d;
    end
  end

  assign healthy_o = healthy_q;
  assign open_o = open_q;
  assign present_o = present_q;
endmodule

@@ rtl/blb_mod.sv @@
// Sequential remainder of a 32-bit value by a small count, one bit a cycle.
module blb_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                num_i,
  input  logic [blb_pkg::CntW-1:0]   den_i,
  output logic                       done_o,
  output logic [blb_pkg::CntW-1:0]   rem_o
);
  logic [31:0] num_q, num_d;
  logic [blb_pkg::CntW:0] rem_q, rem_d, trial;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d;

  assign trial = {rem_q[blb_pkg::CntW-1:0], num_q[31]};

  // Shift in one dividend bit and subtract when it fits.
  always_comb begin
    num_d = num_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q;
    if (start_i) begin
      num_d = num_i; rem_d = '0; cnt_d = 6'd32; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      rem_d = (trial >= {1'b0, den_i}) ? trial - {1'b0, den_i} : trial;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; rem_q <= '0; num_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; rem_q <= rem_d; num_q <= num_d;
    end
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign rem_o = rem_d[blb_pkg::CntW-1:0];
endmodule

@@ rtl/backend_load_balancer_top.sv @@
// Backend load balancer: controller, modulo unit and a chain of slot cells.
// Slot commands go straight to apply and done. Least-connection or least-response
// routes scan the chain first; round-robin or hash routes count eligible slots,
// take the bit-serial remainder and then scan (apply at once if none is eligible).
// Busy drops in the cycle after the result; the receiver cannot stall results.
// Reset clears slot state, counters and registers to their defaults, except the cell chain links.
module backend_load_balancer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  cmd_i,
  input  logic [3:0]  slot_i,
  input  logic        initial_healthy_i,
  input  logic [31:0] client_hash_i,
  input  logic [19:0] response_time_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output logic        done_o,
  output logic        ok_o,
  output logic [3:0]  chosen_slot_o,
  output logic        slot_healthy_o,
  output logic [1:0]  breaker_state_o,
  output logic [31:0] request_total_o,
  output logic [15:0] connection_total_o
);
  localparam int N = blb_pkg::NumSlots;
  localparam int CW = blb_pkg::CntW;

  blb_pkg::state_e state_q, state_d;
  logic [2:0] strat_q;
  logic [7:0] flim_q, bthr_q;
  logic [3:0] cmd_q;
  logic [3:0] slot_q;
  logic init_q;
  logic [31:0] hash_q, rr_q, req_q;
  logic [19:0] rt_q;
  logic [15:0] cg_q;
  logic [4:0] step_q, step_d;
  logic [CW-1:0] n_q, target_q;
  logic found_q;
  logic [3:0] best_q;
  logic ranked, mod_start, mod_done;
  logic [CW-1:0] rem;
  blb_pkg::cell_op_t op;
  blb_pkg::chain_t chain [N+1];
  logic [N-1:0] cell_h, cell_o, cell_p;
  logic rep_sel_ok;
  logic [3:0] rep_slot;
  logic add_rm_ok_q;

  assign ranked = (strat_q == blb_pkg::StratLeastConn) ||
                  (strat_q == blb_pkg::StratLeastResp);
  assign chain[0] = '0;

  // Advance the command sequencer.
  always_comb begin
    state_d = state_q;
    step_d = step_q;
    case (state_q)
      blb_pkg::StIdle: begin
        if (start) begin
          step_d = '0;
          if (cmd_i == blb_pkg::CmdRoute) begin
            state_d = (strat_q == blb_pkg::StratLeastConn ||
                       strat_q == blb_pkg::StratLeastResp) ? blb_pkg::StScan
                                                           : blb_pkg::StCount;
          end else begin
            state_d = blb_pkg::StApply;
          end
        end
      end
      blb_pkg::StCount: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'(N)) state_d = blb_pkg::StDiv;
      end
      blb_pkg::StDiv: begin
        step_d = '0;
        if (mod_done || n_q == '0) state_d = (n_q == '0) ? blb_pkg::StApply
                                                          : blb_pkg::StScan;
      end
      blb_pkg::StScan: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'(N)) state_d = blb_pkg::StApply;
      end
      blb_pkg::StApply: state_d = blb_pkg::StDone;
      blb_pkg::StDone: state_d = blb_pkg::StIdle;
      default: state_d = blb_pkg::StIdle;
    endcase
  end

  // Drive the cell operation from the state.
  always_comb begin
    op = '0;
    op.count_en = (state_q == blb_pkg::StCount) && (step_q == '0);
    op.scan_en = (state_q == blb_pkg::StScan) && (step_q == '0);
    op.apply_en = (state_q == blb_pkg::StApply);
    op.cmd = cmd_q;
    op.slot = slot_q;
    op.slot_valid = 1'b1;
    op.init_h = init_q;
    op.chosen = best_q;
    op.chosen_ok = found_q;
    op.rt = rt_q;
    op.fail_limit = flim_q;
    op.brk_thresh = bthr_q;
  end

  // Decode a per-cell enable from the step so each cell sees its own cycle.
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      blb_pkg::cell_op_t cop;
      always_comb begin
        cop = op;
        cop.count_en = (state_q == blb_pkg::StCount) && (step_q == 5'(g));
        cop.scan_en = (state_q == blb_pkg::StScan) && (step_q == 5'(g));
      end
      blb_cell u_cell (
        .clk_i, .rst_ni, .idx_i(4'(g)), .op_i(cop), .strat_i(strat_q),
        .target_i(target_q), .chain_i(chain[g]), .chain_o(chain[g+1]),
        .healthy_o(cell_h[g]), .open_o(cell_o[g]), .present_o(cell_p[g])
      );
    end
  endgenerate

  // Feed each cell the previous cell's registered word; stage 0 starts empty.
  // (Chain words only matter at the cycle the matching cell is enabled.)

  assign mod_start = (state_q == blb_pkg::StCount) && (step_q == 5'(N));
  blb_mod u_mod (
    .clk_i, .rst_ni, .start_i(mod_start),
    .num_i((strat_q == blb_pkg::StratHash) ? hash_q : rr_q),
    .den_i(n_q), .done_o(mod_done), .rem_o(rem)
  );

  // Hold the command, registers and global counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blb_pkg::StIdle; step_q <= '0;
      strat_q <= blb_pkg::StratRr; flim_q <= 8'd3; bthr_q <= 8'd5;
      rr_q <= '0; req_q <= '0; cg_q <= '0; n_q <= '0; target_q <= '0;
      found_q <= 1'b0; best_q <= '0;
      cmd_q <= '0; slot_q <= '0; init_q <= 1'b0; hash_q <= '0; rt_q <= '0;
    end else begin
      state_q <= state_d; step_q <= step_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          blb_pkg::CfgStrategy: begin strat_q <= cfg_data_i[2:0]; rr_q <= '0; end
          blb_pkg::CfgFailLimit: flim_q <= cfg_data_i;
          blb_pkg::CfgBrkThresh: bthr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == blb_pkg::StIdle && start) begin
        cmd_q <= cmd_i; slot_q <= slot_i; init_q <= initial_healthy_i;
        hash_q <= client_hash_i; rt_q <= response_time_i;
        found_q <= 1'b0; best_q <= '0; n_q <= '0; target_q <= '0;
      end
      if (state_q == blb_pkg::StCount && step_q == 5'(N)) n_q <= chain[N].n;
      if (mod_done) target_q <= rem;
      if (state_q == blb_pkg::StScan && step_q == 5'(N)) begin
        found_q <= chain[N].found;
        best_q <= chain[N].found ? chain[N].best : 4'd0;
      end
      if (state_q == blb_pkg::StApply) begin
        case (cmd_q)
          blb_pkg::CmdRoute: begin
            if (!ranked && strat_q != blb_pkg::StratHash && n_q != '0) rr_q <= rr_q + 32'd1;
            if (found_q) begin
              if (req_q != 32'hFFFF_FFFF) req_q <= req_q + 32'd1;
              if (cg_q != 16'hFFFF) cg_q <= cg_q + 16'd1;
            end
          end
          blb_pkg::CmdSuccess, blb_pkg::CmdFailure: begin
            if (cg_q != 16'd0) cg_q <= cg_q - 16'd1;
          end
          default: ;
        endcase
      end
    end
  end

  // Each cell's chain link carries the running word forward to the next cell.
  // Report the addressed or chosen slot after the update.
  assign rep_sel_ok = (cmd_q != blb_pkg::CmdRoute) || found_q;
  assign rep_slot = (cmd_q == blb_pkg::CmdRoute) ? best_q : slot_q;

  assign busy = (state_q != blb_pkg::StIdle);
  assign done_o = (state_q == blb_pkg::StDone);
  assign ok_o = done_o && (((cmd_q == blb_pkg::CmdRoute) && found_q) ||
                ((cmd_q == blb_pkg::CmdAdd || cmd_q == blb_pkg::CmdRemove) &&
                 (cell_p[slot_q] == (cmd_q == blb_pkg::CmdAdd)) && add_rm_ok_q));
  assign chosen_slot_o = (cmd_q == blb_pkg::CmdRoute) ? best_q : 4'd0;
  assign slot_healthy_o = rep_sel_ok && cell_h[rep_slot];
  assign breaker_state_o = {1'b0, rep_sel_ok && cell_o[rep_slot]};
  assign request_total_o = req_q;
  assign connection_total_o = cg_q;

  // Note whether add or remove changed presence at the update edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) add_rm_ok_q <= 1'b0;
    else if (state_q == blb_pkg::StApply)
      add_rm_ok_q <= (cmd_q == blb_pkg::CmdAdd) ? !cell_p[slot_q] : cell_p[slot_q];
  end
endmodule

@@ rtl/blb_checker.sv @@
// Port-level checker for the backend load balancer, bound to the top level.
`include "backend_load_balancer_top_macros.svh"
module blb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        ok_o,
  input logic [3:0]  chosen_slot_o,
  input logic [31:0] request_total_o
);
  `BLB_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `BLB_ASSERT_IMP(a_done_busy, done_o, busy)
  `BLB_ASSERT_NXT(a_done_idle, done_o, !busy)
  `BLB_ASSERT_IMP(a_req_hold, !done_o, request_total_o == $past(request_total_o))
  `BLB_ASSERT_IMP(a_chosen_zero, done_o && !ok_o, chosen_slot_o == 4'd0)
endmodule

bind backend_load_balancer_top blb_checker u_blb_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .ok_o, .chosen_slot_o, .request_total_o
);
